// File: src/c8ic_pkg.sv
package c8ic_pkg;

    localparam int MEM_AW = 12;
    localparam int ROW_AW = 5;
    localparam logic [11:0] PROG_START = 12'h200;

    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_RUN   = 2'd1,
        OP_READ  = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_INIT,
        ST_FETCH_HI,
        ST_FETCH_LO,
        ST_FETCH_WAIT,
        ST_EXEC,
        ST_CLS,
        ST_SPR_RD,
        ST_SPR_WAIT,
        ST_SPR_ROW,
        ST_BCD1,
        ST_BCD2,
        ST_STORE,
        ST_LOAD_RD,
        ST_LOAD_WAIT,
        ST_LOAD_WR,
        ST_RSP_RD,
        ST_RSP_WAIT,
        ST_DONE,
        ST_OUT
    } state_t;

    localparam logic [7:0] FONT_0_3 [0:79] = '{
        8'hF0, 8'h90, 8'h90, 8'h90, 8'hF0, 8'h20, 8'h60, 8'h20, 8'h20, 8'h70,
        8'hF0, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h10, 8'hF0, 8'h10, 8'hF0,
        8'h90, 8'h90, 8'hF0, 8'h10, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'h10, 8'hF0,
        8'hF0, 8'h80, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h10, 8'h20, 8'h40, 8'h40,
        8'hF0, 8'h90, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h90, 8'hF0, 8'h10, 8'hF0,
        8'hF0, 8'h90, 8'hF0, 8'h90, 8'h90, 8'hE0, 8'h90, 8'hE0, 8'h90, 8'hE0,
        8'hF0, 8'h80, 8'h80, 8'h80, 8'hF0, 8'hE0, 8'h90, 8'h90, 8'h90, 8'hE0,
        8'hF0, 8'h80, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h80, 8'hF0, 8'h80, 8'h80
    };

    function automatic logic [7:0] font_byte(input logic [11:0] a);
        logic [7:0] b;
        b = 8'h00;
        if (a < 12'd80) begin
            b = FONT_0_3[a[6:0]];
        end
        return b;
    endfunction

endpackage

// File: src/c8ic_ram.sv
module c8ic_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [0:DEPTH-1];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: src/chip8_instruction_core_unit.sv
// Channel | Dir | Handshake        | Payload
// s_      | in  | s_tvalid/tready  | tuser: op; tdata: address, write_data, keys, random_byte
// m_      | out | m_tvalid/tready  | tdata: row_pixels, program_counter, draw_flag, beep,
//         |     |                  |        waiting_key, unknown_instruction
// After reset a clearing pass writes the font and zeros into main memory; no
// transfer is taken meanwhile. A byte write or row read passes through the done
// state. An instruction is fetched a byte at a time through the memory's single
// read port; a sprite reads one byte per row and a register block move handles
// one register at a time. The display clear zeros one row a cycle, all 32 rows.
// One item is in flight; s_tready is low until the result transfer.
module chip8_instruction_core_unit #(
    parameter int STACK_DEPTH = 16
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [1:0]   s_tuser,   // op
    input  logic [47:0]  s_tdata,   // address[11:0], write_data[19:12], keys[35:20],
                                    // random_byte[43:36], zero fill
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [79:0]  m_tdata    // row_pixels[63:0], program_counter[75:64],
                                    // draw_flag[76], beep[77], waiting_key[78],
                                    // unknown_instruction[79]
);

    localparam int SPW = $clog2(STACK_DEPTH + 1);
    localparam int SIW = $clog2(STACK_DEPTH);

    c8ic_pkg::state_t state_reg, state_next;

    // Held input item
    logic [1:0]  op_reg;
    logic [11:0] addr_reg;
    logic [7:0]  wdata_reg;
    logic [15:0] keys_reg;
    logic [7:0]  rnd_reg;

    // Architectural state
    logic [7:0]     v_reg [0:15];
    logic [11:0]    stk_reg [0:STACK_DEPTH-1];
    logic [SPW-1:0] sp_reg;
    logic [11:0]    pc_reg;
    logic [15:0]    i_reg;
    logic [7:0]     dt_reg, st_reg;
    logic [63:0]    disp_reg [0:31];

    // Sequencer working registers
    logic [15:0] ins_reg;
    logic [11:0] cnt_reg;      // init address, row counter, block counter
    logic        hit_reg;
    logic [63:0] row_reg;
    logic        drew_reg, beep_reg, wait_reg, bad_reg;
    logic [7:0]  bcd_reg;

    // Memory port
    logic        mem_we;
    logic [11:0] mem_waddr, mem_raddr;
    logic [7:0]  mem_wdata, mem_rdata;

    c8ic_ram #(.WIDTH(8), .DEPTH(4096)) u_mem (
        .aclk(aclk), .we(mem_we), .waddr(mem_waddr), .wdata(mem_wdata),
        .raddr(mem_raddr), .rdata(mem_rdata)
    );

    logic [3:0] xr, yr, nib;
    logic [7:0] lo, vx, vy;
    assign xr  = ins_reg[11:8];
    assign yr  = ins_reg[7:4];
    assign nib = ins_reg[3:0];
    assign lo  = ins_reg[7:0];
    assign vx  = v_reg[xr];
    assign vy  = v_reg[yr];

    // Shared byte ALU for the 8XYN group
    logic [8:0] alu_sum;
    logic [7:0] alu_res, alu_flag;
    logic       alu_setf, alu_bad;
    always_comb begin
        alu_sum  = {1'b0, vx} + {1'b0, vy};
        alu_res  = vy;
        alu_flag = 8'd0;
        alu_setf = 1'b1;
        alu_bad  = 1'b0;
        case (nib)
            4'h0: begin alu_res = vy; alu_setf = 1'b0; end
            4'h1: begin alu_res = vx | vy; alu_setf = 1'b0; end
            4'h2: begin alu_res = vx & vy; alu_setf = 1'b0; end
            4'h3: begin alu_res = vx ^ vy; alu_setf = 1'b0; end
            4'h4: begin alu_res = alu_sum[7:0]; alu_flag = {7'd0, alu_sum[8]}; end
            4'h5: begin alu_res = vx - vy; alu_flag = {7'd0, vx >= vy}; end
            4'h6: begin alu_res = {1'b0, vy[7:1]}; alu_flag = {7'd0, vy[0]}; end
            4'h7: begin alu_res = vy - vx; alu_flag = {7'd0, vy >= vx}; end
            4'hE: begin alu_res = {vy[6:0], 1'b0}; alu_flag = {7'd0, vy[7]}; end
            default: begin alu_bad = 1'b1; alu_setf = 1'b0; end
        endcase
    end

    // Lowest pressed key
    logic [3:0] key_idx;
    logic       key_any;
    always_comb begin
        key_idx = 4'd0;
        key_any = 1'b0;
        for (int k = 15; k >= 0; k--) begin
            if (keys_reg[k]) begin
                key_idx = 4'(k);
                key_any = 1'b1;
            end
        end
    end

    // Timer values after an FX15 or FX18 load, before the count-down of this cycle
    logic [7:0] dt_src, st_src;
    assign dt_src = (ins_reg[15:12] == 4'hF && lo == 8'h15) ? vx : dt_reg;
    assign st_src = (ins_reg[15:12] == 4'hF && lo == 8'h18) ? vx : st_reg;

    // Sprite row: byte placed at column, wrapped
    logic [5:0]  col;
    logic [4:0]  line;
    logic [63:0] spr_mask;
    logic [127:0] spr_wide;
    assign col  = vx[5:0];
    assign line = 5'(vy[4:0] + cnt_reg[4:0]);
    always_comb begin
        spr_wide = {mem_rdata, 120'd0} >> col;
        spr_mask = spr_wide[127:64] | spr_wide[63:0];
    end

    // BCD by compare and subtract
    logic [7:0] hund, rem100, tens, ones;
    always_comb begin
        hund   = (vx >= 8'd200) ? 8'd2 : (vx >= 8'd100) ? 8'd1 : 8'd0;
        rem100 = vx - 8'(hund * 8'd100);
        tens   = 8'd0;
        ones   = rem100;
        for (int t = 9; t >= 1; t--) begin
            if (tens == 8'd0 && rem100 >= 8'(t * 10)) begin
                tens = 8'(t);
                ones = rem100 - 8'(t * 10);
            end
        end
    end

    logic [11:0] pc2, pc4;
    logic [15:0] i_k;
    assign pc2 = pc_reg + 12'd2;
    assign pc4 = pc_reg + 12'd4;
    assign i_k = i_reg + {4'd0, cnt_reg};

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            c8ic_pkg::ST_INIT:
                if (cnt_reg == 12'hFFF) state_next = c8ic_pkg::ST_IDLE;
            c8ic_pkg::ST_IDLE:
                if (s_tvalid) begin
                    if (s_tuser == c8ic_pkg::OP_RUN) state_next = c8ic_pkg::ST_FETCH_HI;
                    else state_next = c8ic_pkg::ST_DONE;
                end
            c8ic_pkg::ST_FETCH_HI:   state_next = c8ic_pkg::ST_FETCH_LO;
            c8ic_pkg::ST_FETCH_LO:   state_next = c8ic_pkg::ST_FETCH_WAIT;
            c8ic_pkg::ST_FETCH_WAIT: state_next = c8ic_pkg::ST_EXEC;
            c8ic_pkg::ST_EXEC: begin
                state_next = c8ic_pkg::ST_OUT;
                case (ins_reg[15:12])
                    4'h0: if (lo == 8'hE0) state_next = c8ic_pkg::ST_CLS;
                    4'hD: if (nib != 4'd0) state_next = c8ic_pkg::ST_SPR_RD;
                    4'hF: case (lo)
                        8'h33: state_next = c8ic_pkg::ST_BCD1;
                        8'h55: state_next = c8ic_pkg::ST_STORE;
                        8'h65: state_next = c8ic_pkg::ST_LOAD_RD;
                        default: ;
                    endcase
                    default: ;
                endcase
            end
            c8ic_pkg::ST_CLS:
                if (cnt_reg[4:0] == 5'd31) state_next = c8ic_pkg::ST_OUT;
            c8ic_pkg::ST_SPR_RD:   state_next = c8ic_pkg::ST_SPR_WAIT;
            c8ic_pkg::ST_SPR_WAIT: state_next = c8ic_pkg::ST_SPR_ROW;
            c8ic_pkg::ST_SPR_ROW:
                state_next = (cnt_reg[3:0] + 4'd1 == nib) ? c8ic_pkg::ST_OUT
                                                          : c8ic_pkg::ST_SPR_RD;
            c8ic_pkg::ST_BCD1: state_next = c8ic_pkg::ST_BCD2;
            c8ic_pkg::ST_BCD2: state_next = c8ic_pkg::ST_OUT;
            c8ic_pkg::ST_STORE:
                if (cnt_reg[3:0] == xr) state_next = c8ic_pkg::ST_OUT;
            c8ic_pkg::ST_LOAD_RD:   state_next = c8ic_pkg::ST_LOAD_WAIT;
            c8ic_pkg::ST_LOAD_WAIT: state_next = c8ic_pkg::ST_LOAD_WR;
            c8ic_pkg::ST_LOAD_WR:
                state_next = (cnt_reg[3:0] == xr) ? c8ic_pkg::ST_OUT
                                                  : c8ic_pkg::ST_LOAD_RD;
            c8ic_pkg::ST_DONE: state_next = c8ic_pkg::ST_OUT;
            c8ic_pkg::ST_OUT:  if (m_tready) state_next = c8ic_pkg::ST_IDLE;
            default: state_next = c8ic_pkg::ST_IDLE;
        endcase
    end

    // Memory port drive; hold the read address through the wait state
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = addr_reg;
        mem_wdata = wdata_reg;
        mem_raddr = pc_reg;
        unique case (state_reg)
            c8ic_pkg::ST_INIT: begin
                mem_we    = 1'b1;
                mem_waddr = cnt_reg;
                mem_wdata = c8ic_pkg::font_byte(cnt_reg);
            end
            c8ic_pkg::ST_DONE: mem_we = (op_reg == c8ic_pkg::OP_WRITE);
            c8ic_pkg::ST_FETCH_HI: mem_raddr = pc_reg;
            c8ic_pkg::ST_FETCH_LO: mem_raddr = pc_reg + 12'd1;
            c8ic_pkg::ST_SPR_RD, c8ic_pkg::ST_SPR_WAIT,
            c8ic_pkg::ST_LOAD_RD, c8ic_pkg::ST_LOAD_WAIT: mem_raddr = i_k[11:0];
            c8ic_pkg::ST_EXEC: begin
                mem_we    = (ins_reg[15:12] == 4'hF) && (lo == 8'h33);
                mem_waddr = i_reg[11:0];
                mem_wdata = hund;
            end
            c8ic_pkg::ST_BCD1: begin
                mem_we    = 1'b1;
                mem_waddr = i_reg[11:0] + 12'd1;
                mem_wdata = bcd_reg;
            end
            c8ic_pkg::ST_BCD2: begin
                mem_we    = 1'b1;
                mem_waddr = i_reg[11:0] + 12'd2;
                mem_wdata = ones;
            end
            c8ic_pkg::ST_STORE: begin
                mem_we    = 1'b1;
                mem_waddr = i_k[11:0];
                mem_wdata = v_reg[cnt_reg[3:0]];
            end
            default: ;
        endcase
    end

    assign s_tready = (state_reg == c8ic_pkg::ST_IDLE);
    assign m_tvalid = (state_reg == c8ic_pkg::ST_OUT);
    assign m_tdata  = {bad_reg, wait_reg, beep_reg, drew_reg, pc_reg, row_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= c8ic_pkg::ST_INIT;
            cnt_reg   <= 12'd0;
            pc_reg    <= c8ic_pkg::PROG_START;
            sp_reg    <= '0;
            i_reg     <= 16'd0;
            dt_reg    <= 8'd0;
            st_reg    <= 8'd0;
            for (int r = 0; r < 16; r++) v_reg[r] <= 8'd0;
            for (int r = 0; r < STACK_DEPTH; r++) stk_reg[r] <= 12'd0;
            for (int r = 0; r < 32; r++) disp_reg[r] <= 64'd0;
        end else begin
            state_reg <= state_next;
            unique case (state_reg)
                c8ic_pkg::ST_INIT: cnt_reg <= cnt_reg + 12'd1;
                c8ic_pkg::ST_IDLE: if (s_tvalid) begin
                    op_reg    <= s_tuser;
                    addr_reg  <= s_tdata[11:0];
                    wdata_reg <= s_tdata[19:12];
                    keys_reg  <= s_tdata[35:20];
                    rnd_reg   <= s_tdata[43:36];
                    drew_reg  <= 1'b0;
                    beep_reg  <= 1'b0;
                    wait_reg  <= 1'b0;
                    bad_reg   <= 1'b0;
                    row_reg   <= 64'd0;
                    cnt_reg   <= 12'd0;
                    hit_reg   <= 1'b0;
                end
                c8ic_pkg::ST_DONE:
                    if (op_reg == c8ic_pkg::OP_READ) row_reg <= disp_reg[addr_reg[4:0]];
                c8ic_pkg::ST_FETCH_LO: ins_reg[15:8] <= mem_rdata;
                c8ic_pkg::ST_FETCH_WAIT: ins_reg[7:0] <= mem_rdata;
                c8ic_pkg::ST_EXEC: begin
                    // Timers advance once per instruction cycle, after any load
                    dt_reg   <= (dt_src != 8'd0) ? dt_src - 8'd1 : 8'd0;
                    st_reg   <= (st_src != 8'd0) ? st_src - 8'd1 : 8'd0;
                    beep_reg <= (st_src == 8'd1);
                    bcd_reg  <= tens;
                    case (ins_reg[15:12])
                        4'h0: begin
                            if (lo == 8'hE0) pc_reg <= pc2;
                            else if (lo == 8'hEE) begin
                                if (sp_reg == '0 || sp_reg > SPW'(STACK_DEPTH)) begin
                                    pc_reg <= pc2;
                                end else begin
                                    pc_reg <= stk_reg[SIW'(sp_reg - 1'b1)] + 12'd2;
                                    stk_reg[SIW'(sp_reg - 1'b1)] <= 12'd0;
                                    sp_reg <= sp_reg - 1'b1;
                                end
                            end else bad_reg <= 1'b1;
                        end
                        4'h1: pc_reg <= ins_reg[11:0];
                        4'h2: begin
                            if (sp_reg >= SPW'(STACK_DEPTH)) pc_reg <= pc2;
                            else begin
                                stk_reg[SIW'(sp_reg)] <= pc_reg;
                                sp_reg <= sp_reg + 1'b1;
                                pc_reg <= ins_reg[11:0];
                            end
                        end
                        4'h3: pc_reg <= (vx == lo) ? pc4 : pc2;
                        4'h4: pc_reg <= (vx != lo) ? pc4 : pc2;
                        4'h5: pc_reg <= (vx == vy) ? pc4 : pc2;
                        4'h6: begin v_reg[xr] <= lo; pc_reg <= pc2; end
                        4'h7: begin v_reg[xr] <= vx + lo; pc_reg <= pc2; end
                        4'h8: begin
                            if (alu_bad) bad_reg <= 1'b1;
                            else begin
                                // Flag wins when VF is also the destination
                                if (!alu_setf || xr != 4'hF) v_reg[xr] <= alu_res;
                                if (alu_setf) v_reg[15] <= alu_flag;
                                pc_reg <= pc2;
                            end
                        end
                        4'h9: pc_reg <= (vx != vy) ? pc4 : pc2;
                        4'hA: begin i_reg <= {4'd0, ins_reg[11:0]}; pc_reg <= pc2; end
                        4'hB: pc_reg <= ins_reg[11:0] + {4'd0, v_reg[0]};
                        4'hC: begin v_reg[xr] <= rnd_reg & lo; pc_reg <= pc2; end
                        4'hD: begin
                            drew_reg <= 1'b1;
                            pc_reg   <= pc2;
                            if (nib == 4'd0) v_reg[15] <= 8'd0;
                        end
                        4'hE: begin
                            if (lo == 8'h9E) pc_reg <= keys_reg[vx[3:0]] ? pc4 : pc2;
                            else if (lo == 8'hA1) pc_reg <= keys_reg[vx[3:0]] ? pc2 : pc4;
                            else bad_reg <= 1'b1;
                        end
                        default: begin
                            case (lo)
                                8'h07: begin v_reg[xr] <= dt_reg; pc_reg <= pc2; end
                                8'h0A: begin
                                    if (key_any) begin
                                        v_reg[xr] <= {4'd0, key_idx};
                                        pc_reg    <= pc2;
                                    end else wait_reg <= 1'b1;
                                end
                                8'h15, 8'h18: pc_reg <= pc2;
                                8'h1E: begin i_reg <= i_reg + {8'd0, vx}; pc_reg <= pc2; end
                                8'h29: begin
                                    i_reg  <= {8'd0, 4'd0, vx[3:0]} * 16'd5;
                                    pc_reg <= pc2;
                                end
                                8'h33, 8'h55, 8'h65: pc_reg <= pc2;
                                default: bad_reg <= 1'b1;
                            endcase
                        end
                    endcase
                end
                c8ic_pkg::ST_CLS: begin
                    disp_reg[cnt_reg[4:0]] <= 64'd0;
                    cnt_reg <= cnt_reg + 12'd1;
                end
                c8ic_pkg::ST_SPR_ROW: begin
                    if ((disp_reg[line] & spr_mask) != 64'd0) hit_reg <= 1'b1;
                    disp_reg[line] <= disp_reg[line] ^ spr_mask;
                    if (cnt_reg[3:0] + 4'd1 == nib) begin
                        v_reg[15] <= {7'd0, hit_reg || ((disp_reg[line] & spr_mask) != 64'd0)};
                    end
                    cnt_reg <= cnt_reg + 12'd1;
                end
                c8ic_pkg::ST_STORE: begin
                    cnt_reg <= cnt_reg + 12'd1;
                    if (cnt_reg[3:0] == xr) i_reg <= i_k + 16'd1;
                end
                c8ic_pkg::ST_LOAD_WR: begin
                    v_reg[cnt_reg[3:0]] <= mem_rdata;
                    cnt_reg <= cnt_reg + 12'd1;
                    if (cnt_reg[3:0] == xr) i_reg <= i_k + 16'd1;
                end
                default: ;
            endcase
        end
    end

endmodule

// File: sim/tb_chip8_instruction_core_unit.sv
`timescale 1ns / 100ps

module tb_chip8_instruction_core_unit;

    typedef struct packed {
        c8ic_pkg::op_t op;
        logic [11:0]   address;
        logic [7:0]    write_data;
        logic [15:0]   keys;
        logic [7:0]    random_byte;
    } cmd_t;

    // Declared from the top bit down to match m_tdata
    typedef struct packed {
        logic        unknown_instruction;
        logic        waiting_key;
        logic        beep;
        logic        draw_flag;
        logic [11:0] program_counter;
        logic [63:0] row_pixels;
    } status_t;

    localparam int WATCHDOG_LIMIT = 20000;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [1:0]  s_tuser;
    logic [47:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [79:0] m_tdata;

    chip8_instruction_core_unit uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // Shadow machine state
    logic [7:0]  mem_img [0:4095];
    logic [63:0] screen [0:31];
    logic [7:0]  vreg [0:15];
    logic [11:0] call_stack [0:15];
    int          sp;
    logic [11:0] pc;
    logic [15:0] idx;
    logic [7:0]  delay_tmr;
    logic [7:0]  sound_tmr;

    cmd_t    pending_cmds[$];
    status_t expected_status[$];
    int      error_count;
    int      idle_cycles;
    int      sent_count;
    bit      hold_sink;
    bit      stim_done;

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch %s: got %h expected %h", what, got, want);
        error_count++;
    endtask

    function automatic void reset_shadow();
        for (int i = 0; i < 4096; i++)
            mem_img[i] = (i < 80) ? c8ic_pkg::FONT_0_3[i] : 8'h00;
        for (int i = 0; i < 32; i++) screen[i] = '0;
        for (int i = 0; i < 16; i++) begin
            vreg[i] = '0;
            call_stack[i] = '0;
        end
        sp = 0;
        pc = c8ic_pkg::PROG_START;
        idx = '0;
        delay_tmr = '0;
        sound_tmr = '0;
    endfunction

    // Run one fetched instruction against the shadow state
    function automatic void run_instruction(input logic [15:0] ins, input logic [15:0] keys,
                                            input logic [7:0] rnd, inout status_t st);
        logic [3:0]  xr, yr;
        logic [7:0]  lo, vx, vy, res, flg;
        logic [8:0]  sum;
        logic        sets_flag, hit, down;
        logic [11:0] nnn;
        int          k;
        xr = ins[11:8];
        yr = ins[7:4];
        lo = ins[7:0];
        nnn = ins[11:0];
        vx = vreg[xr];
        vy = vreg[yr];
        case (ins[15:12])
            4'h0: begin
                if (lo == 8'hE0) begin
                    for (int i = 0; i < 32; i++) screen[i] = '0;
                    pc = pc + 12'd2;
                end else if (lo == 8'hEE) begin
                    if (sp == 0) begin
                        pc = pc + 12'd2;
                    end else begin
                        sp--;
                        pc = call_stack[sp] + 12'd2;
                        call_stack[sp] = '0;
                    end
                end else begin
                    st.unknown_instruction = 1'b1;
                end
            end
            4'h1: pc = nnn;
            4'h2: begin
                if (sp >= 16) begin
                    pc = pc + 12'd2;
                end else begin
                    call_stack[sp] = pc;
                    sp++;
                    pc = nnn;
                end
            end
            4'h3: pc = pc + ((vx == lo) ? 12'd4 : 12'd2);
            4'h4: pc = pc + ((vx != lo) ? 12'd4 : 12'd2);
            4'h5: pc = pc + ((vx == vy) ? 12'd4 : 12'd2);
            4'h6: begin vreg[xr] = lo; pc = pc + 12'd2; end
            4'h7: begin vreg[xr] = vx + lo; pc = pc + 12'd2; end
            4'h8: begin
                flg = vreg[15];
                sets_flag = 1'b1;
                res = '0;
                case (ins[3:0])
                    4'h0: begin res = vy; sets_flag = 1'b0; end
                    4'h1: begin res = vx | vy; sets_flag = 1'b0; end
                    4'h2: begin res = vx & vy; sets_flag = 1'b0; end
                    4'h3: begin res = vx ^ vy; sets_flag = 1'b0; end
                    4'h4: begin sum = vx + vy; res = sum[7:0]; flg = {7'd0, sum[8]}; end
                    4'h5: begin res = vx - vy; flg = {7'd0, vx >= vy}; end
                    4'h6: begin res = vy >> 1; flg = {7'd0, vy[0]}; end
                    4'h7: begin res = vy - vx; flg = {7'd0, vy >= vx}; end
                    4'hE: begin res = vy << 1; flg = {7'd0, vy[7]}; end
                    default: st.unknown_instruction = 1'b1;
                endcase
                if (!st.unknown_instruction) begin
                    vreg[xr] = res;
                    if (sets_flag) vreg[15] = flg;
                    pc = pc + 12'd2;
                end
            end
            4'h9: pc = pc + ((vx != vy) ? 12'd4 : 12'd2);
            4'hA: begin idx = {4'd0, nnn}; pc = pc + 12'd2; end
            4'hB: pc = nnn + {4'd0, vreg[0]};
            4'hC: begin vreg[xr] = rnd & lo; pc = pc + 12'd2; end
            4'hD: begin
                hit = 1'b0;
                for (k = 0; k < ins[3:0]; k++) begin
                    logic [7:0]  bits;
                    logic [4:0]  line;
                    logic [5:0]  px;
                    bits = mem_img[12'(idx + k)];
                    line = 5'(vy[4:0] + k);
                    for (int b = 0; b < 8; b++) begin
                        if (bits[7 - b]) begin
                            px = 6'(vx[5:0] + b);
                            if (screen[line][63 - px]) hit = 1'b1;
                            screen[line][63 - px] = ~screen[line][63 - px];
                        end
                    end
                end
                vreg[15] = {7'd0, hit};
                st.draw_flag = 1'b1;
                pc = pc + 12'd2;
            end
            4'hE: begin
                down = keys[vx[3:0]];
                if (lo == 8'h9E) pc = pc + (down ? 12'd4 : 12'd2);
                else if (lo == 8'hA1) pc = pc + (down ? 12'd2 : 12'd4);
                else st.unknown_instruction = 1'b1;
            end
            default: begin
                case (lo)
                    8'h07: vreg[xr] = delay_tmr;
                    8'h0A: begin
                        for (k = 0; k < 16; k++) if (keys[k]) break;
                        if (k == 16) st.waiting_key = 1'b1;
                        else vreg[xr] = 8'(k);
                    end
                    8'h15: delay_tmr = vx;
                    8'h18: sound_tmr = vx;
                    8'h1E: idx = idx + {8'd0, vx};
                    8'h29: idx = {12'd0, vx[3:0]} * 16'd5;
                    8'h33: begin
                        mem_img[idx[11:0]] = 8'(vx / 100);
                        mem_img[12'(idx + 1)] = 8'((vx / 10) % 10);
                        mem_img[12'(idx + 2)] = 8'(vx % 10);
                    end
                    8'h55: for (k = 0; k <= xr; k++) begin
                        mem_img[idx[11:0]] = vreg[k];
                        idx = idx + 16'd1;
                    end
                    8'h65: for (k = 0; k <= xr; k++) begin
                        vreg[k] = mem_img[idx[11:0]];
                        idx = idx + 16'd1;
                    end
                    default: st.unknown_instruction = 1'b1;
                endcase
                if (!st.unknown_instruction && !st.waiting_key) pc = pc + 12'd2;
            end
        endcase
    endfunction

    function automatic status_t predict_status(input cmd_t c);
        status_t st;
        st = '0;
        case (c.op)
            c8ic_pkg::OP_WRITE: mem_img[c.address] = c.write_data;
            c8ic_pkg::OP_RUN: begin
                run_instruction({mem_img[pc], mem_img[12'(pc + 1)]}, c.keys, c.random_byte, st);
                if (delay_tmr != 0) delay_tmr--;
                if (sound_tmr != 0) begin
                    if (sound_tmr == 1) st.beep = 1'b1;
                    sound_tmr--;
                end
            end
            c8ic_pkg::OP_READ: st.row_pixels = screen[c.address[4:0]];
            default: ;
        endcase
        st.program_counter = pc;
        return st;
    endfunction

    // Driver: present queued commands, idle a random number of cycles between them
    int src_gap;
    initial src_gap = 0;
    always @(posedge aclk) begin
        cmd_t c;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tuser  <= '0;
            s_tdata  <= '0;
        end else begin
            if (s_tvalid && s_tready) begin
                expected_status.push_back(predict_status(pending_cmds.pop_front()));
                sent_count++;
                src_gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 8);
            end
            if (!(s_tvalid && !s_tready)) begin
                if (src_gap > 0) begin
                    src_gap--;
                    s_tvalid <= 1'b0;
                end else if (pending_cmds.size() > 0) begin
                    c = pending_cmds[0];
                    s_tvalid <= 1'b1;
                    s_tuser  <= c.op;
                    s_tdata  <= {4'd0, c.random_byte, c.keys, c.write_data, c.address};
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: compare each result transfer with the oldest prediction
    int sink_gap;
    initial sink_gap = 0;
    always @(posedge aclk) begin
        status_t got, want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got = m_tdata;
                if (expected_status.size() == 0) begin
                    report_mismatch("unexpected result", m_tdata[63:0], '0);
                end else begin
                    want = expected_status.pop_front();
                    if (got.row_pixels !== want.row_pixels)
                        report_mismatch("row_pixels", got.row_pixels, want.row_pixels);
                    if (got.program_counter !== want.program_counter)
                        report_mismatch("program_counter", got.program_counter,
                                        want.program_counter);
                    if (got.draw_flag !== want.draw_flag)
                        report_mismatch("draw_flag", got.draw_flag, want.draw_flag);
                    if (got.beep !== want.beep)
                        report_mismatch("beep", got.beep, want.beep);
                    if (got.waiting_key !== want.waiting_key)
                        report_mismatch("waiting_key", got.waiting_key, want.waiting_key);
                    if (got.unknown_instruction !== want.unknown_instruction)
                        report_mismatch("unknown_instruction", got.unknown_instruction,
                                        want.unknown_instruction);
                end
                sink_gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 8);
            end
            if (hold_sink) begin
                m_tready <= 1'b0;
            end else if (sink_gap > 0) begin
                sink_gap--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Watchdog: count cycles without any transfer; covers the clearing pass too
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || hold_sink)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic cmd_t make_cmd(input c8ic_pkg::op_t op, input logic [11:0] a,
                                      input logic [7:0] d);
        cmd_t c;
        c.op = op;
        c.address = a;
        c.write_data = d;
        c.keys = 16'($urandom);
        c.random_byte = 8'($urandom);
        return c;
    endfunction

    task automatic put_word(input logic [11:0] a, input logic [15:0] w);
        pending_cmds.push_back(make_cmd(c8ic_pkg::OP_WRITE, a, w[15:8]));
        pending_cmds.push_back(make_cmd(c8ic_pkg::OP_WRITE, 12'(a + 1), w[7:0]));
    endtask

    task automatic put_run(input logic [15:0] keys);
        cmd_t c;
        c = make_cmd(c8ic_pkg::OP_RUN, 12'($urandom), 8'($urandom));
        c.keys = keys;
        pending_cmds.push_back(c);
    endtask

    task automatic drain();
        while (pending_cmds.size() > 0 || expected_status.size() > 0) @(posedge aclk);
    endtask

    // Random instruction, mostly well formed, occasionally any word
    function automatic logic [15:0] rand_ins();
        logic [15:0] w;
        w = 16'($urandom);
        case ($urandom_range(0, 19))
            0: w = 16'h00E0;
            1: w = 16'h00EE;
            2: w = {4'h2, 12'h200 + 12'($urandom_range(0, 60) * 2)};
            3: w = {4'h1, 12'h200 + 12'($urandom_range(0, 60) * 2)};
            4, 5: w[15:12] = 4'h6;
            6: w[15:12] = 4'h7;
            7, 8: begin
                w[15:12] = 4'h8;
                w[3:0] = ($urandom_range(0, 9) == 9) ? 4'hE : 4'($urandom_range(0, 8));
            end
            9: w[15:12] = 4'($urandom_range(3, 5));
            10: w[15:12] = 4'h9;
            11: w = {4'hA, 12'($urandom)};
            12: w[15:12] = 4'hC;
            13: w = {4'hD, w[11:4], 4'($urandom_range(0, 15))};
            14: w = {4'hE, w[11:8], ($urandom_range(0, 1) ? 8'h9E : 8'hA1)};
            15, 16: begin
                logic [7:0] fx [9];
                fx = '{8'h07, 8'h0A, 8'h15, 8'h18, 8'h1E, 8'h29, 8'h33, 8'h55, 8'h65};
                w = {4'hF, w[11:8], fx[$urandom_range(0, 8)]};
            end
            17: w = {4'hB, 12'h200 + 12'($urandom_range(0, 40))};
            default: ;
        endcase
        return w;
    endfunction

    logic [15:0] prog [22];
    initial begin
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tuser = '0;
        s_tdata = '0;
        m_tready = 1'b0;
        error_count = 0;
        idle_cycles = 0;
        sent_count = 0;
        hold_sink = 1'b0;
        stim_done = 1'b0;
        reset_shadow();
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed program covering groups 0, 2, 5, 6, 8, D, E, F and odd cases
        prog = '{16'h60FF, 16'h6101, 16'h8014, 16'h8015, 16'h8106, 16'h810E, 16'h8017,
                 16'hF029, 16'hD015, 16'h00E0, 16'hD01F, 16'hF033, 16'hFF55, 16'hFF65,
                 16'h2230, 16'hF00A, 16'hE09E, 16'hE0A1, 16'h5018, 16'h8008, 16'hF118,
                 16'h0123};
        for (int i = 0; i < 22; i++) put_word(12'(12'h200 + 2 * i), prog[i]);
        put_word(12'h230, 16'h00EE);
        put_word(12'hFFE, 16'h1200);
        pending_cmds.push_back(make_cmd(c8ic_pkg::OP_WRITE, 12'hFFF, 8'hFF));
        for (int i = 0; i < 24; i++) put_run(i == 15 ? 16'h0000 : 16'($urandom));
        put_run(16'h8000);
        pending_cmds.push_back(make_cmd(c8ic_pkg::OP_READ, 12'hFFF, 8'h00));
        pending_cmds.push_back(make_cmd(c8ic_pkg::OP_READ, 12'h000, 8'hFF));
        pending_cmds.push_back(make_cmd(c8ic_pkg::OP_NONE, 12'hABC, 8'h55));
        drain();

        // Receiver holds off while commands pile up on the input
        for (int i = 0; i < 8; i++)
            pending_cmds.push_back(make_cmd(c8ic_pkg::OP_READ, 12'($urandom), 8'($urandom)));
        hold_sink = 1'b1;
        repeat (300) @(posedge aclk);
        hold_sink = 1'b0;
        drain();

        // Random programs: load a block, jump into it, run a burst
        while (sent_count < 950) begin
            logic [11:0] base;
            int n;
            base = 12'h200;
            n = $urandom_range(4, 12);
            for (int i = 0; i < n; i++) put_word(12'(base + 2 * i), rand_ins());
            put_word(12'(base + 2 * n), 16'h1200);
            if ($urandom_range(0, 9) == 0)
                pending_cmds.push_back(make_cmd(c8ic_pkg::OP_WRITE, 12'($urandom),
                                                8'($urandom)));
            for (int i = 0; i < 2 * n; i++) begin
                if ($urandom_range(0, 9) == 0)
                    pending_cmds.push_back(make_cmd(c8ic_pkg::OP_READ, 12'($urandom),
                                                    8'($urandom)));
                else if ($urandom_range(0, 40) == 0)
                    pending_cmds.push_back(make_cmd(c8ic_pkg::OP_NONE, 12'($urandom),
                                                    8'($urandom)));
                else
                    put_run($urandom_range(0, 4) == 0 ? 16'h0000 : 16'($urandom));
            end
            // Restore the program counter to the block start
            drain();
            while (pc != 12'h200) begin
                put_word(pc, 16'h1200);
                put_run(16'hFFFF);
                drain();
            end
        end
        for (int i = 0; i < 32; i++)
            pending_cmds.push_back(make_cmd(c8ic_pkg::OP_READ, 12'(i), 8'($urandom)));
        drain();
        repeat (100) @(posedge aclk);
        if (error_count == 0 && expected_status.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
